// ===== sv/oefsd_pkg.sv =====
// ----------------------------------------------------------------------------
// oefsd_pkg: shared definitions for the One Euro filter settle detector
// Field widths, fixed-point constants, register indexes, item kinds and the
// command and status types that pass between the controller and datapath.
// ----------------------------------------------------------------------------
package oefsd_pkg;

    localparam int VAL_W      = 32;
    localparam int US_W       = 20;
    localparam int FC_W       = 16;
    localparam int THR_W      = 24;
    localparam int RATE_W     = 40;
    localparam int MAGX_W     = 33;
    localparam int ARATE_W    = 38;
    localparam int MUL_AW     = 39;
    localparam int TWO_PI_W   = 19;
    localparam int NUM_W      = 55;
    localparam int DEN_W      = 56;
    localparam int DVD_W      = 52;
    localparam int QUO_W      = 52;
    localparam int STEP_W     = 6;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 104;

    localparam int COEFF_FRAC_BITS_DEFAULT = 16;

    localparam logic [STEP_W-1:0]   RATE_DIV_STEPS = 6'd52;
    localparam logic [TWO_PI_W-1:0] TWO_PI_Q16     = 19'd411775;
    localparam logic [US_W-1:0]     USEC_PER_SEC   = 20'd1000000;
    localparam logic [DEN_W-1:0]    COEFF_DEN_BASE = 56'd16777216000000;
    localparam logic [ARATE_W-1:0]  RATE_LIMIT     = 38'h3F_FFFF_FFFF;
    localparam logic [FC_W-1:0]     CUTOFF_MAX     = 16'hFFFF;

    localparam logic [KIND_W-1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNSETTLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TARE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CUTOFF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_CUTOFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSETTLE_THR = 3'd4;

    localparam logic [FC_W-1:0]  MIN_CUTOFF_RESET   = 16'd256;
    localparam logic [FC_W-1:0]  BETA_GAIN_RESET    = 16'd0;
    localparam logic [FC_W-1:0]  DERIV_CUTOFF_RESET = 16'd256;
    localparam logic [THR_W-1:0] SETTLE_THR_RESET   = 24'd256;
    localparam logic [THR_W-1:0] UNSETTLE_THR_RESET = 24'd1024;

    typedef enum logic [3:0] {
        OP_PREP,
        OP_RATE_DIV,
        OP_NUM_D,
        OP_COEF_DIV_D,
        OP_SMOOTH_R,
        OP_BETA,
        OP_NUM_S,
        OP_COEF_DIV_S,
        OP_SMOOTH_V,
        OP_EVENT
    } op_t;

    typedef struct packed {
        logic capture;
        logic start;
        op_t  op;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_status_t;

endpackage

// ===== sv/oefsd_mul.sv =====
// ----------------------------------------------------------------------------
// oefsd_mul: shift-and-add multiplier
// Unsigned product, one multiplier bit per cycle, done pulses when complete.
// ----------------------------------------------------------------------------
module oefsd_mul #(
    parameter int AW = 39,
    parameter int BW = 20
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] prod
);

    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [PW-1:0] acc_reg, mcand_reg;
    logic [BW-1:0] mplier_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && cnt_reg == CW'(1);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg    <= '0;
            mcand_reg  <= PW'(a);
            mplier_reg <= b;
            cnt_reg    <= CW'(BW);
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            cnt_reg    <= cnt_reg - CW'(1);
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== sv/oefsd_div.sv =====
// ----------------------------------------------------------------------------
// oefsd_div: restoring divider
// One quotient bit per cycle; the remainder starts from a given value and
// dividend bits are shifted in from the top.
// ----------------------------------------------------------------------------
module oefsd_div
    import oefsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DEN_W-1:0]  rem_init,
    input  logic [DVD_W-1:0]  dvd,
    input  logic [DEN_W-1:0]  den,
    input  logic [STEP_W-1:0] steps,
    output logic              done,
    output logic [QUO_W-1:0]  quo,
    output logic [DEN_W-1:0]  rem
);

    logic [DEN_W-1:0]  rem_reg, den_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg, done_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && cnt_reg == STEP_W'(1);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            den_reg <= den;
            dvd_reg <= dvd;
            quo_reg <= '0;
            cnt_reg <= steps;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
            end else begin
                rem_reg <= trial[DEN_W-1:0];
            end
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg - STEP_W'(1);
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== sv/oefsd_datapath.sv =====
// ----------------------------------------------------------------------------
// oefsd_datapath: filter state, configuration and arithmetic
// Holds the registers, the shared multiplier and divider, and carries out
// each operation that the controller issues.
// ----------------------------------------------------------------------------
module oefsd_datapath
    import oefsd_pkg::*;
#(
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [KIND_W-1:0]     s_kind,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic [M_TDATA_W-1:0]  m_data
);

    localparam int CFB    = COEFF_FRAC_BITS;
    localparam int MUL_BW = (CFB + 1 > US_W) ? CFB + 1 : US_W;
    localparam int PW     = MUL_AW + MUL_BW;

    function automatic logic [VAL_W-1:0] sat33(input logic [VAL_W:0] v);
        if (v[VAL_W] != v[VAL_W-1]) begin
            sat33 = v[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            sat33 = v[VAL_W-1:0];
        end
    endfunction

    logic [FC_W-1:0]  min_cutoff_reg, beta_gain_reg, deriv_cutoff_reg;
    logic [THR_W-1:0] settle_thr_reg, unsettle_thr_reg;

    logic [VAL_W-1:0]  fv_reg, sv_reg, tare_reg;
    logic [RATE_W-1:0] frate_reg;
    logic              settled_reg;
    logic              simple_done_reg;

    logic [VAL_W-1:0]  x_reg;
    logic [US_W-1:0]   us_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [MAGX_W-1:0] magx_reg;
    logic              xneg_reg, rneg_reg;
    logic [RATE_W-1:0] raw_reg, new_rate_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [CFB:0]      a_reg;
    logic [FC_W-1:0]   cut_reg;
    op_t               cur_op_reg;

    logic [VAL_W-1:0]  reading_reg, settled_weight_reg, rate_out_reg;
    logic              settled_out_reg;

    // Operand forming
    logic [MAGX_W-1:0]  diffx, diffx_mag;
    logic [RATE_W:0]    rdiff, rdiff_mag;
    logic [RATE_W-1:0]  nrate_mag;
    logic [ARATE_W-1:0] arate;
    logic [FC_W-1:0]    fc_sel;
    logic [34:0]        two_pi_fc;
    logic [MUL_AW-1:0]  mul_a;
    logic [MUL_BW-1:0]  mul_b;
    logic               mul_start, mul_done;
    logic [PW-1:0]      mul_prod;

    logic [DVD_W:0]     rate_dvd_full;
    logic [DVD_W-1:0]   rate_dvd;
    logic [DEN_W-1:0]   coef_den;
    logic               is_rate_div, div_start, div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [DEN_W-1:0]   div_rem;

    assign diffx     = {x_reg[VAL_W-1], x_reg} - {fv_reg[VAL_W-1], fv_reg};
    assign diffx_mag = diffx[MAGX_W-1] ? MAGX_W'(0) - diffx : diffx;
    assign rdiff     = {raw_reg[RATE_W-1], raw_reg} - {frate_reg[RATE_W-1], frate_reg};
    assign rdiff_mag = rdiff[RATE_W] ? (RATE_W+1)'(0) - rdiff : rdiff;
    assign nrate_mag = new_rate_reg[RATE_W-1] ? RATE_W'(0) - new_rate_reg : new_rate_reg;
    assign arate     = nrate_mag[ARATE_W-1:0];
    assign fc_sel    = (cmd.op == OP_NUM_D) ? deriv_cutoff_reg : cut_reg;
    assign two_pi_fc = 35'(TWO_PI_Q16) * 35'(fc_sel);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_NUM_D, OP_NUM_S: begin
                mul_a = MUL_AW'(two_pi_fc);
                mul_b = MUL_BW'(us_reg);
            end
            OP_SMOOTH_R: begin
                mul_a = rdiff_mag[MUL_AW-1:0];
                mul_b = MUL_BW'(a_reg);
            end
            OP_BETA: begin
                mul_a = MUL_AW'(arate);
                mul_b = MUL_BW'(beta_gain_reg);
            end
            OP_SMOOTH_V: begin
                mul_a = MUL_AW'(magx_reg);
                mul_b = MUL_BW'(a_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = cmd.start && (cmd.op == OP_NUM_D || cmd.op == OP_NUM_S ||
                       cmd.op == OP_SMOOTH_R || cmd.op == OP_BETA || cmd.op == OP_SMOOTH_V);

    oefsd_mul #(
        .AW(MUL_AW),
        .BW(MUL_BW)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    // The raw rate is rounded by adding half the divisor before dividing.
    assign rate_dvd_full = (DVD_W+1)'(magx_reg) * (DVD_W+1)'(USEC_PER_SEC);
    assign rate_dvd      = rate_dvd_full[DVD_W-1:0] + DVD_W'(us_reg >> 1);
    assign coef_den      = DEN_W'(num_reg) + COEFF_DEN_BASE;
    assign is_rate_div   = cmd.op == OP_RATE_DIV;
    assign div_start     = cmd.start && (cmd.op == OP_RATE_DIV ||
                           cmd.op == OP_COEF_DIV_D || cmd.op == OP_COEF_DIV_S);

    oefsd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .rem_init(is_rate_div ? DEN_W'(0) : DEN_W'(num_reg)),
        .dvd     (is_rate_div ? rate_dvd : DVD_W'(0)),
        .den     (is_rate_div ? DEN_W'(us_reg) : coef_den),
        .steps   (is_rate_div ? RATE_DIV_STEPS : STEP_W'(CFB)),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    // Result shaping
    logic [ARATE_W-1:0] q_sat;
    logic [RATE_W-1:0]  raw_pos, raw_val;
    logic               round_up;
    logic [CFB:0]       a_val;
    logic [PW-1:0]      rsum, rshift, bsum, bshift;
    logic [RATE_W:0]    nrate, lim_pos, lim_neg;
    logic [RATE_W-1:0]  nrate_sat;
    logic [FC_W:0]      cut_sum;
    logic [FC_W-1:0]    cut_val;
    logic [VAL_W+1:0]   nval;
    logic               set_now, drop_now;

    assign q_sat    = (div_quo > QUO_W'(RATE_LIMIT)) ? RATE_LIMIT : div_quo[ARATE_W-1:0];
    assign raw_pos  = RATE_W'(q_sat);
    assign raw_val  = xneg_reg ? RATE_W'(0) - raw_pos : raw_pos;
    assign round_up = {div_rem, 1'b0} >= {1'b0, den_reg};
    assign a_val    = (CFB+1)'(div_quo[CFB-1:0]) + (CFB+1)'(round_up);

    assign rsum   = mul_prod + (PW'(1) << (CFB - 1));
    assign rshift = rsum >> CFB;

    assign lim_pos = (RATE_W+1)'(RATE_LIMIT);
    assign lim_neg = (RATE_W+1)'(0) - lim_pos;
    assign nrate   = rneg_reg
                   ? {frate_reg[RATE_W-1], frate_reg} - (RATE_W+1)'(rshift[MUL_AW-1:0])
                   : {frate_reg[RATE_W-1], frate_reg} + (RATE_W+1)'(rshift[MUL_AW-1:0]);

    always_comb begin
        if ($signed(nrate) > $signed(lim_pos)) begin
            nrate_sat = lim_pos[RATE_W-1:0];
        end else if ($signed(nrate) < $signed(lim_neg)) begin
            nrate_sat = lim_neg[RATE_W-1:0];
        end else begin
            nrate_sat = nrate[RATE_W-1:0];
        end
    end

    assign bsum    = mul_prod + PW'(128);
    assign bshift  = bsum >> 8;
    assign cut_sum = {1'b0, bshift[FC_W-1:0]} + {1'b0, min_cutoff_reg};
    assign cut_val = ((|bshift[PW-1:FC_W]) || cut_sum[FC_W]) ? CUTOFF_MAX : cut_sum[FC_W-1:0];

    assign nval = xneg_reg
                ? {{2{fv_reg[VAL_W-1]}}, fv_reg} - (VAL_W+2)'(rshift[MAGX_W-1:0])
                : {{2{fv_reg[VAL_W-1]}}, fv_reg} + (VAL_W+2)'(rshift[MAGX_W-1:0]);

    assign set_now  = arate < ARATE_W'(settle_thr_reg);
    assign drop_now = (arate > ARATE_W'(unsettle_thr_reg)) && settled_reg;

    // State with a defined reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_cutoff_reg   <= MIN_CUTOFF_RESET;
            beta_gain_reg    <= BETA_GAIN_RESET;
            deriv_cutoff_reg <= DERIV_CUTOFF_RESET;
            settle_thr_reg   <= SETTLE_THR_RESET;
            unsettle_thr_reg <= UNSETTLE_THR_RESET;
            fv_reg           <= '0;
            frate_reg        <= '0;
            sv_reg           <= '0;
            tare_reg         <= '0;
            settled_reg      <= 1'b0;
            simple_done_reg  <= 1'b0;
        end else begin
            simple_done_reg <= cmd.start && (cmd.op == OP_PREP || cmd.op == OP_EVENT);
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MIN_CUTOFF:   min_cutoff_reg   <= cfg_wdata[FC_W-1:0];
                    CFG_BETA_GAIN:    beta_gain_reg    <= cfg_wdata[FC_W-1:0];
                    CFG_DERIV_CUTOFF: deriv_cutoff_reg <= cfg_wdata[FC_W-1:0];
                    CFG_SETTLE_THR:   settle_thr_reg   <= cfg_wdata;
                    CFG_UNSETTLE_THR: unsettle_thr_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (cmd.start && cmd.op == OP_EVENT) begin
                case (kind_reg)
                    KIND_UNSETTLE: settled_reg <= 1'b0;
                    KIND_TARE: begin
                        tare_reg <= fv_reg;
                        sv_reg   <= fv_reg;
                    end
                    default: begin
                    end
                endcase
            end
            // Commit: the flag is judged on the new rate, and a drop keeps
            // the value from before this sample.
            if (mul_done && cur_op_reg == OP_SMOOTH_V) begin
                fv_reg    <= nval[VAL_W-1:0];
                frate_reg <= new_rate_reg;
                if (set_now) begin
                    settled_reg <= 1'b1;
                end else if (drop_now) begin
                    settled_reg <= 1'b0;
                    sv_reg      <= fv_reg;
                end
            end
        end
    end

    // Working and output registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg    <= s_tdata[VAL_W-1:0];
            us_reg   <= (s_tdata[VAL_W+US_W-1:VAL_W] == '0) ? US_W'(1)
                                                            : s_tdata[VAL_W+US_W-1:VAL_W];
            kind_reg <= s_kind;
        end
        if (cmd.start) begin
            cur_op_reg <= cmd.op;
            case (cmd.op)
                OP_PREP: begin
                    magx_reg <= diffx_mag;
                    xneg_reg <= diffx[MAGX_W-1];
                end
                OP_SMOOTH_R: rneg_reg <= rdiff[RATE_W];
                OP_COEF_DIV_D, OP_COEF_DIV_S: den_reg <= coef_den;
                default: begin
                end
            endcase
        end
        if (div_done) begin
            if (cur_op_reg == OP_RATE_DIV) begin
                raw_reg <= raw_val;
            end else begin
                a_reg <= a_val;
            end
        end
        if (mul_done) begin
            case (cur_op_reg)
                OP_NUM_D, OP_NUM_S: num_reg      <= mul_prod[NUM_W-1:0];
                OP_SMOOTH_R:        new_rate_reg <= nrate_sat;
                OP_BETA:            cut_reg      <= cut_val;
                default: begin
                end
            endcase
        end
        if (cmd.load_out) begin
            reading_reg        <= sat33({fv_reg[VAL_W-1], fv_reg} - {tare_reg[VAL_W-1], tare_reg});
            settled_weight_reg <= sat33({sv_reg[VAL_W-1], sv_reg} - {tare_reg[VAL_W-1], tare_reg});
            settled_out_reg    <= settled_reg;
            if (frate_reg[RATE_W-1:VAL_W-1] == '0 || frate_reg[RATE_W-1:VAL_W-1] == '1) begin
                rate_out_reg <= frate_reg[VAL_W-1:0];
            end else begin
                rate_out_reg <= frate_reg[RATE_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                                    : {1'b0, {(VAL_W-1){1'b1}}};
            end
        end
    end

    assign status.done = mul_done || div_done || simple_done_reg;
    assign m_data = M_TDATA_W'({rate_out_reg, settled_out_reg, settled_weight_reg, reading_reg});

endmodule

// ===== sv/oefsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// oefsd_ctrl: operation sequencer
// Accepts an item, steps the datapath through its operations and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module oefsd_ctrl
    import oefsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic [KIND_W-1:0] s_kind,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dp_cmd_t           cmd,
    input  dp_status_t        status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg;
    op_t    op_reg;
    logic   m_tvalid_reg;
    logic   load_out;

    function automatic op_t next_op(input op_t op);
        case (op)
            OP_PREP:       next_op = OP_RATE_DIV;
            OP_RATE_DIV:   next_op = OP_NUM_D;
            OP_NUM_D:      next_op = OP_COEF_DIV_D;
            OP_COEF_DIV_D: next_op = OP_SMOOTH_R;
            OP_SMOOTH_R:   next_op = OP_BETA;
            OP_BETA:       next_op = OP_NUM_S;
            OP_NUM_S:      next_op = OP_COEF_DIV_S;
            OP_COEF_DIV_S: next_op = OP_SMOOTH_V;
            default:       next_op = OP_PREP;
        endcase
    endfunction

    assign load_out = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_PREP;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= (s_kind == KIND_SAMPLE) ? OP_PREP : OP_EVENT;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (status.done) begin
                        if (op_reg == OP_SMOOTH_V || op_reg == OP_EVENT) begin
                            state_reg <= ST_OUT;
                        end else begin
                            op_reg    <= next_op(op_reg);
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_OUT: begin
                    if (load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready     = state_reg == ST_IDLE;
    assign m_tvalid     = m_tvalid_reg;
    assign cmd.capture  = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.start    = state_reg == ST_ISSUE;
    assign cmd.op       = op_reg;
    assign cmd.load_out = load_out;

`ifndef SYNTHESIS
    a_done_only_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |-> state_reg == ST_WAIT)
        else $error("datapath finished an operation that was not awaited");

    a_accept_issues: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_ISSUE && !s_tready)
        else $error("accepted item did not start an operation");

    a_load_presents: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid && state_reg == ST_IDLE)
        else $error("loaded result not presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> !(m_tvalid_reg && !m_tready))
        else $error("result overwritten while stalled");
`endif

endmodule

// ===== sv/one_euro_filter_settle_detect_unit.sv =====
// ----------------------------------------------------------------------------
// one_euro_filter_settle_detect_unit: One Euro weight filter with settling
// Smooths load cell weight samples, estimates their rate of change, and keeps
// a settled flag with hysteresis together with the last settled weight.
// ----------------------------------------------------------------------------
// Usage. Input items arrive on the s_ stream: s_tuser carries the kind
// (sample, unsettle event or tare capture) and s_tdata carries the sample and
// the elapsed microseconds. Each input item gives exactly one result item on
// the m_ stream with the reading, the last settled weight, the settled flag
// and the rate estimate, all taken after the item has been applied.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wdata; the user must write them only while the block is idle, which
// the block itself does not enforce; they take effect on the next item.
// One item is worked on at a time. The work on a sample item is set by the
// shift-and-add multiplier, used five times at one bit a cycle over MB bits,
// where MB is the larger of 20 and COEFF_FRAC_BITS + 1, and the restoring
// divider, which takes 52 steps for the rate and COEFF_FRAC_BITS steps for
// each coefficient.
// Reset clears the filter state, the flag and the tare offset, and loads the
// register defaults. When the receiver stalls, the finished result waits in
// the output register; the next item is still accepted and processed, and
// only its own result waits until the output register is free.
// ----------------------------------------------------------------------------
module one_euro_filter_settle_detect_unit
    import oefsd_pkg::*;
#(
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // sample[31:0], elapsed_us[51:32], zero pad
    input  logic [KIND_W-1:0]     s_tuser,  // kind[1:0]
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata   // reading[31:0], settled_weight[63:32],
                                            // settled[64], rate_estimate[96:65], zero pad
);

    // The controller and datapath talk only through these two structs.
    dp_cmd_t    cmd;
    dp_status_t status;

    oefsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_kind  (s_tuser),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd),
        .status  (status)
    );

    oefsd_datapath #(
        .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .s_kind   (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_data   (m_tdata)
    );

endmodule
